// ----- hw/rtl/d2fx_pkg.sv -----
// ----------------------------------------------------------------------------
// d2fx_pkg
// Shared constants, types and tables for the ASCII decimal to fixed-point
// converter.
// ----------------------------------------------------------------------------
package d2fx_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int MAX_FRAC_DIGITS = 9;
	localparam int INT_BITS        = 31;

	localparam int CHAR_W  = 8;
	localparam int VALUE_W = 48;
	localparam int FSUM_W  = 30;
	localparam int FCNT_W  = 4;
	localparam int REM_W   = FSUM_W + 1;
	localparam int MAG_W   = INT_BITS + FRAC_BITS;
	localparam int DCNT_W  = $clog2(FRAC_BITS);

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	localparam logic [63:0] VALUE_MAX_MAG = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(FRAC_BITS - 1);

	typedef struct packed {
		logic char_step;
		logic load;
		logic div_step;
		logic out_load;
	} d2fx_cmd_t;

	typedef struct packed {
		logic is_nul;
	} d2fx_status_t;

	function automatic logic [FSUM_W-1:0] pow_ten(input logic [FCNT_W-1:0] n);
		logic [FSUM_W-1:0] p;
		unique case (n)
			4'd0:    p = FSUM_W'(1);
			4'd1:    p = FSUM_W'(10);
			4'd2:    p = FSUM_W'(100);
			4'd3:    p = FSUM_W'(1000);
			4'd4:    p = FSUM_W'(10000);
			4'd5:    p = FSUM_W'(100000);
			4'd6:    p = FSUM_W'(1000000);
			4'd7:    p = FSUM_W'(10000000);
			4'd8:    p = FSUM_W'(100000000);
			4'd9:    p = FSUM_W'(1000000000);
			default: p = FSUM_W'(1);
		endcase
		return p;
	endfunction

endpackage

// ----- hw/rtl/d2fx_ctrl.sv -----
// ----------------------------------------------------------------------------
// d2fx_ctrl
// Controller: character handshake, fraction divide sequencing and result
// word handoff.
// ----------------------------------------------------------------------------
module d2fx_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_stall,
	output logic                  result_valid,
	input  logic                  result_stall,
	input  d2fx_pkg::d2fx_status_t status,
	output d2fx_pkg::d2fx_cmd_t    cmd
);
	import d2fx_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t              state_q;
	logic [DCNT_W-1:0]   dcnt_q;
	logic                rvalid_q;
	logic                accept;
	logic                out_free;

	assign char_stall   = (state_q != ST_IDLE);
	assign result_valid = rvalid_q;
	assign accept       = char_valid && !char_stall;
	assign out_free     = !rvalid_q || !result_stall;

	always_comb begin
		cmd.char_step = accept && !status.is_nul;
		cmd.load      = accept && status.is_nul;
		cmd.div_step  = (state_q == ST_DIV);
		cmd.out_load  = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			dcnt_q   <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				rvalid_q <= 1'b1;
			else if (rvalid_q && !result_stall)
				rvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_DIV;
						dcnt_q  <= '0;
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DIV_LAST)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/d2fx_dp.sv -----
// ----------------------------------------------------------------------------
// d2fx_dp
// Datapath: digit accumulation, restoring fraction divider, result
// assembly and output register.
// ----------------------------------------------------------------------------
module d2fx_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [d2fx_pkg::CHAR_W-1:0]   character,
	input  d2fx_pkg::d2fx_cmd_t           cmd,
	output d2fx_pkg::d2fx_status_t        status,
	output logic signed [d2fx_pkg::VALUE_W-1:0] value,
	output logic                          invalid,
	output logic                          saturated
);
	import d2fx_pkg::*;

	// parser state
	logic [INT_BITS-1:0]  isum_q;
	logic [FSUM_W-1:0]    fsum_q;
	logic [FCNT_W-1:0]    fcnt_q;
	logic                 point_q;
	logic                 neg_q;
	logic                 first_q;
	logic                 bad_q;
	logic                 clamp_q;

	// divide and snapshot
	logic [REM_W-1:0]     rem_q;
	logic [FSUM_W-1:0]    dvsr_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [INT_BITS-1:0]  int_q;
	logic                 sneg_q;
	logic                 sbad_q;
	logic                 sclamp_q;

	// result word
	logic [VALUE_W-1:0]   value_q;
	logic                 invalid_q;
	logic                 saturated_q;

	logic                 is_digit;
	logic [3:0]           digit;
	logic [INT_BITS+3:0]  int_next;
	logic [INT_BITS+3:0]  int_limit;
	logic [FSUM_W-1:0]    frac_next;
	logic [REM_W-1:0]     rem_dbl;
	logic                 rem_ge;
	logic [MAG_W-1:0]     mag;
	logic [63:0]          mag_ext;
	logic [VALUE_W-1:0]   mag_clip;
	logic                 out_clip;

	assign status.is_nul = (character == CH_NUL);
	assign is_digit      = (character >= CH_ZERO) && (character <= CH_NINE);
	assign digit         = 4'(character - CH_ZERO);
	assign int_next      = (INT_BITS+4)'(isum_q) * (INT_BITS+4)'(10)
	                       + (INT_BITS+4)'(digit);
	assign int_limit     = (INT_BITS+4)'({INT_BITS{1'b1}});
	assign frac_next     = FSUM_W'(fsum_q * FSUM_W'(10) + FSUM_W'(digit));

	assign rem_dbl = {rem_q[REM_W-2:0], 1'b0};
	assign rem_ge  = (rem_dbl >= REM_W'(dvsr_q));

	assign mag      = {int_q, quo_q};
	assign mag_ext  = 64'(mag);
	assign out_clip = (mag_ext > VALUE_MAX_MAG);
	assign mag_clip = out_clip ? VALUE_W'(VALUE_MAX_MAG) : VALUE_W'(mag_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isum_q  <= '0;
			fsum_q  <= '0;
			fcnt_q  <= '0;
			point_q <= 1'b0;
			neg_q   <= 1'b0;
			first_q <= 1'b1;
			bad_q   <= 1'b0;
			clamp_q <= 1'b0;
		end else if (cmd.load) begin
			isum_q  <= '0;
			fsum_q  <= '0;
			fcnt_q  <= '0;
			point_q <= 1'b0;
			neg_q   <= 1'b0;
			first_q <= 1'b1;
			bad_q   <= 1'b0;
			clamp_q <= 1'b0;
		end else if (cmd.char_step) begin
			first_q <= 1'b0;
			if (!bad_q) begin
				priority if (is_digit) begin
					if (point_q) begin
						if (fcnt_q < FCNT_W'(MAX_FRAC_DIGITS)) begin
							fsum_q <= frac_next;
							fcnt_q <= fcnt_q + 1'b1;
						end
					end else if (int_next > int_limit) begin
						isum_q  <= {INT_BITS{1'b1}};
						clamp_q <= 1'b1;
					end else begin
						isum_q <= INT_BITS'(int_next);
					end
				end else if (character == CH_POINT) begin
					if (point_q)
						bad_q <= 1'b1;
					else
						point_q <= 1'b1;
				end else if (character == CH_MINUS && first_q) begin
					neg_q <= 1'b1;
				end else begin
					bad_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q    <= REM_W'(fsum_q);
			dvsr_q   <= pow_ten(fcnt_q);
			quo_q    <= '0;
			int_q    <= isum_q;
			sneg_q   <= neg_q;
			sbad_q   <= bad_q;
			sclamp_q <= clamp_q;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? (rem_dbl - REM_W'(dvsr_q)) : rem_dbl;
			quo_q <= {quo_q[FRAC_BITS-2:0], rem_ge};
		end
		if (cmd.out_load) begin
			if (sbad_q) begin
				value_q     <= '0;
				invalid_q   <= 1'b1;
				saturated_q <= 1'b0;
			end else begin
				value_q     <= sneg_q ? (VALUE_W'(0) - mag_clip) : mag_clip;
				invalid_q   <= 1'b0;
				saturated_q <= sclamp_q || out_clip;
			end
		end
	end

	assign value     = signed'(value_q);
	assign invalid   = invalid_q;
	assign saturated = saturated_q;

endmodule

// ----- hw/rtl/decimal_ascii_to_fixed.sv -----
// ----------------------------------------------------------------------------
// decimal_ascii_to_fixed
// Streaming ASCII decimal string to signed fixed-point converter.
// ----------------------------------------------------------------------------
// Digits, sign and point characters: one per cycle, back to back.
// NUL terminator: restoring fraction divide (one quotient bit per cycle),
// then the result word and result_valid are registered once the output
// register is free. Character input stalls through the divide and the
// result load, longer while the previous result word is still held.
// Reset (arst_n low, async) clears the parser and drops result_valid.
module decimal_ascii_to_fixed (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                char_valid,
	output logic                                char_stall,
	input  logic [d2fx_pkg::CHAR_W-1:0]         character,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [d2fx_pkg::VALUE_W-1:0] value,
	output logic                                invalid,
	output logic                                saturated
);
	import d2fx_pkg::*;

	d2fx_cmd_t    cmd;
	d2fx_status_t status;

	d2fx_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	d2fx_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.character (character),
		.cmd       (cmd),
		.status    (status),
		.value     (value),
		.invalid   (invalid),
		.saturated (saturated)
	);

endmodule

// ----- hw/rtl/d2fx_chk.sv -----
// ----------------------------------------------------------------------------
// d2fx_chk
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module d2fx_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                char_valid,
	input logic                                char_stall,
	input logic [d2fx_pkg::CHAR_W-1:0]         character,
	input logic                                result_valid,
	input logic                                result_stall,
	input logic signed [d2fx_pkg::VALUE_W-1:0] value,
	input logic                                invalid,
	input logic                                saturated
);
	import d2fx_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	a_hold_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(value) && $stable(invalid)
		&& $stable(saturated))
		else $error("result word changed while stalled");

	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && invalid |-> value == '0 && !saturated)
		else $error("invalid result carries value or saturation");

	a_nul_busy: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && character == CH_NUL |=> char_stall)
		else $error("input not stalled during fraction divide");

	a_nul_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && character == CH_NUL && !result_valid
		|=> !result_valid)
		else $error("result word appeared before divide finished");

endmodule

bind decimal_ascii_to_fixed d2fx_chk u_d2fx_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.char_valid   (char_valid),
	.char_stall   (char_stall),
	.character    (character),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.value        (value),
	.invalid      (invalid),
	.saturated    (saturated)
);

// ----- dv/tb_decimal_ascii_to_fixed.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_decimal_ascii_to_fixed
// Streams ASCII number text into the converter one word at a time and checks
// every fixed-point result against a parser tracked inside the bench. Covers
// sign handling, disallowed characters, clamping and fraction limits, then
// random strings under several sender/receiver idle mixes and back-pressure.
// ----------------------------------------------------------------------------
module tb_decimal_ascii_to_fixed;
	import d2fx_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [63:0] INT_LIMIT = (64'd1 << INT_BITS) - 64'd1;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic                      invalid;
		logic                      saturated;
	} fixed_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       char_valid = 1'b0;
	logic                       char_stall;
	logic [CHAR_W-1:0]          character = '0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic signed [VALUE_W-1:0]  value;
	logic                       invalid;
	logic                       saturated;

	decimal_ascii_to_fixed dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.character    (character),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.invalid      (invalid),
		.saturated    (saturated)
	);

	always #6 clk = ~clk;

	// parser state tracked by the bench
	logic [INT_BITS-1:0] int_acc = '0;
	logic [FSUM_W-1:0]   frac_acc = '0;
	logic [FCNT_W-1:0]   frac_cnt = '0;
	bit                  point_seen = 0;
	bit                  negative = 0;
	bit                  at_start = 1;
	bit                  bad_seen = 0;
	bit                  clamped = 0;

	fixed_result_t pending_results[$];
	fixed_result_t want;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 0;
	logic hold_on = 1'b0;

	int mismatches = 0;
	int words_sent = 0;
	int strings_sent = 0;
	int results_checked = 0;
	int invalid_count = 0;
	int saturated_count = 0;

	task automatic track_char(input logic [CHAR_W-1:0] c);
		logic [63:0] mag, frac, divisor, nxt;
		logic [7:0] digit;
		fixed_result_t r;
		bit was_first;
		was_first = at_start;
		if (c == CH_NUL) begin
			r.value = '0;
			r.invalid = 1'b0;
			r.saturated = 1'b0;
			if (bad_seen) begin
				r.invalid = 1'b1;
			end else begin
				mag = 64'(int_acc) << FRAC_BITS;
				frac = '0;
				if (frac_cnt != 0) begin
					divisor = 64'd1;
					repeat (frac_cnt) divisor = divisor * 64'd10;
					frac = (64'(frac_acc) << FRAC_BITS) / divisor;
				end
				mag = mag + frac;
				r.saturated = clamped;
				if (mag > VALUE_MAX_MAG) begin
					mag = VALUE_MAX_MAG;
					r.saturated = 1'b1;
				end
				r.value = negative ? VALUE_W'(64'd0 - mag) : VALUE_W'(mag);
			end
			pending_results.push_back(r);
			strings_sent++;
			if (r.invalid) invalid_count++;
			if (r.saturated) saturated_count++;
			int_acc = '0;
			frac_acc = '0;
			frac_cnt = '0;
			point_seen = 0;
			negative = 0;
			at_start = 1;
			bad_seen = 0;
			clamped = 0;
		end else begin
			at_start = 0;
			if (!bad_seen) begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					digit = c - CH_ZERO;
					if (point_seen) begin
						if (frac_cnt < MAX_FRAC_DIGITS) begin
							frac_acc = FSUM_W'(frac_acc * 10 + digit);
							frac_cnt = frac_cnt + 1'b1;
						end
					end else begin
						nxt = 64'(int_acc) * 64'd10 + 64'(digit);
						if (nxt > INT_LIMIT) begin
							nxt = INT_LIMIT;
							clamped = 1;
						end
						int_acc = INT_BITS'(nxt);
					end
				end else if (c == CH_POINT) begin
					if (point_seen) bad_seen = 1;
					else point_seen = 1;
				end else if (c == CH_MINUS && was_first) begin
					negative = 1;
				end else begin
					bad_seen = 1;
				end
			end
		end
	endtask

	// called just after a rising edge; leaves char_valid high
	task automatic send_char(input logic [CHAR_W-1:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		character <= c;
		do @(posedge clk); while (char_stall);
		words_sent++;
		track_char(c);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i]);
		send_char(CH_NUL);
	endtask

	task automatic wait_drained();
		char_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic send_random_string();
		logic [CHAR_W-1:0] txt [0:39];
		int len, n, kind, pos;
		len = 0;
		kind = $urandom_range(99);
		if (kind < 85) begin
			if ($urandom_range(2) == 0) begin
				txt[len] = CH_MINUS;
				len++;
			end
			n = ($urandom_range(9) == 0) ? $urandom_range(12, 8) : $urandom_range(4, 0);
			repeat (n) begin
				txt[len] = CH_ZERO + 8'($urandom_range(9));
				len++;
			end
			if ($urandom_range(9) < 6) begin
				txt[len] = CH_POINT;
				len++;
				n = ($urandom_range(9) == 0) ? $urandom_range(12, 8) : $urandom_range(5, 0);
				repeat (n) begin
					txt[len] = CH_ZERO + 8'($urandom_range(9));
					len++;
				end
			end
			// broken sequence: one stray word dropped in somewhere
			if (kind >= 70) begin
				pos = $urandom_range(len);
				for (int i = len; i > pos; i--) txt[i] = txt[i-1];
				case ($urandom_range(2))
					0: txt[pos] = CH_MINUS;
					1: txt[pos] = CH_POINT;
					default: txt[pos] = 8'($urandom_range(255, 1));
				endcase
				len++;
			end
		end else if (kind < 95) begin
			n = $urandom_range(6, 1);
			repeat (n) begin
				txt[len] = 8'($urandom_range(255, 1));
				len++;
			end
		end else if (kind < 98) begin
			len = 0;
		end else begin
			txt[0] = CH_MINUS;
			len = 1;
		end
		for (int i = 0; i < len; i++) send_char(txt[i]);
		send_char(CH_NUL);
	endtask

	task automatic test_empty_and_sign();
		send_text("");
		send_text("-");
		send_text("-0");
		send_text("-.5");
		send_text("7.25");
	endtask

	task automatic test_disallowed_chars();
		send_text("1..");
		send_text("1-");
		send_char(8'hFF);
		send_char(CH_NUL);
	endtask

	task automatic test_digit_limits();
		send_text("9999999999");
		send_text(".0000000009");
	endtask

	task automatic test_random_phase(input int send_pct, input int recv_pct, input int n_words);
		int start;
		send_idle_pct = send_pct;
		recv_stall_pct <= recv_pct;
		start = words_sent;
		while (words_sent - start < n_words) send_random_string();
		wait_drained();
	endtask

	task automatic test_result_hold();
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		hold_req = 1;
		repeat (25) send_random_string();
		wait_drained();
	endtask

	task automatic test_sender_pause();
		send_idle_pct = 36;
		recv_stall_pct <= 36;
		repeat (8) begin
			send_random_string();
			wait_drained();
		end
	endtask

	always @(posedge clk)
		result_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);

	// long receiver hold, counted here
	initial begin
		forever begin
			wait (hold_req);
			hold_on <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on <= 1'b0;
			hold_req = 0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: unexpected result value=%0d invalid=%0b saturated=%0b",
						value, invalid, saturated);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (value !== want.value || invalid !== want.invalid ||
					saturated !== want.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp value=%0d invalid=%0b saturated=%0b, %s%0d %0b %0b",
							want.value, want.invalid, want.saturated, "got ",
							value, invalid, saturated);
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_sign();
		test_disallowed_chars();
		test_digit_limits();
		wait_drained();
		test_random_phase(0, 0, 250);
		test_random_phase(87, 0, 250);
		test_random_phase(0, 87, 250);
		test_random_phase(36, 36, 250);
		test_result_hold();
		test_sender_pause();
		recv_stall_pct <= 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("tb: %0d words in %0d strings, %0d results checked (%0d invalid, %0d saturated)",
			words_sent, strings_sent, results_checked, invalid_count, saturated_count);
		$display("tb: idle mixes none/sender/receiver/both, long receiver hold, drained pauses");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: %0d mismatches, %0d results never seen", mismatches,
				pending_results.size());
			$display("tb: failure");
		end
		$finish;
	end

endmodule
